// ===== rtl/assert_macros.svh =====
// shared assertion macros, clocked on clk with rst_n low masking checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// antecedent at one edge implies consequent at the next
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/chi_pkg.sv =====
package chi_pkg;

    localparam int BUCKETS_DEF     = 1024;
    localparam int POOL_NODES_DEF  = 4096;
    localparam int ID_BITS_DEF     = 18;

    localparam int FIELD_ID_BITS   = 18;
    localparam int CFG_BITS        = 11;
    localparam int BUCKET_OUT_BITS = 10;
    localparam int COUNT_BITS      = 32;

    localparam int TABLE_SIZE_RST  = 1024;

    localparam int HASH_MOVIE      = 2003;
    localparam int HASH_USER       = 1003;

endpackage

// ===== rtl/chi_ram.sv =====
module chi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/chained_hash_insert_core.sv =====
// chained_hash_insert_core: insert-only hash table with separate chaining.
// Input channel (in_valid/in_ready) takes one (user_id, movie_id) key per beat.
// Output channel (out_valid/out_ready) gives one result beat per key: bucket,
// collided and dropped flags, and the running insert and collision counts.
// cfg_we/cfg_wdata write table_size (0 acts as 1, above BUCKETS acts as
// BUCKETS); a write clears the table and the node pool, not the counts.
// Each key passes the multiply, the sum, the bit-serial remainder unit (one
// quotient bit per cycle over the ID_BITS + 12 bit hash), the head read and
// the write-back, in that order.
// One key is in flight; the next is taken once the last is written back.
// The input is taken while a finished result still waits in the output
// register; a stalled receiver holds the next key before its head write.
// Reset, and every table_size write, starts a clearing pass over all BUCKETS
// head memory entries (1024 by default) during which in_ready is low.
`include "assert_macros.svh"

module chained_hash_insert_core #(
    parameter int BUCKETS    = chi_pkg::BUCKETS_DEF,
    parameter int POOL_NODES = chi_pkg::POOL_NODES_DEF,
    parameter int ID_BITS    = chi_pkg::ID_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [chi_pkg::CFG_BITS-1:0]          cfg_wdata,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [chi_pkg::FIELD_ID_BITS-1:0]     user_id,
    input  logic [chi_pkg::FIELD_ID_BITS-1:0]     movie_id,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [chi_pkg::BUCKET_OUT_BITS-1:0]   bucket,
    output logic                                  collided,
    output logic                                  dropped,
    output logic [chi_pkg::COUNT_BITS-1:0]        insert_count,
    output logic [chi_pkg::COUNT_BITS-1:0]        collision_count
);

    localparam int BKT_BITS  = $clog2(BUCKETS);
    localparam int SIZE_BITS = $clog2(BUCKETS + 1);
    localparam int REM_BITS  = SIZE_BITS + 1;
    localparam int LINK_BITS = $clog2(POOL_NODES + 1);
    localparam int NODE_AW   = $clog2(POOL_NODES);
    localparam int KEY_BITS  = 2 * ID_BITS;
    localparam int HASH_BITS = ID_BITS + 12;
    localparam int CNT_BITS  = $clog2(HASH_BITS);
    localparam int EXT_BITS  = (ID_BITS > chi_pkg::FIELD_ID_BITS) ?
                               ID_BITS : chi_pkg::FIELD_ID_BITS;
    localparam int OUT_EXT   = (BKT_BITS > chi_pkg::BUCKET_OUT_BITS) ?
                               BKT_BITS : chi_pkg::BUCKET_OUT_BITS;
    localparam int SIZE_RST  = (chi_pkg::TABLE_SIZE_RST > BUCKETS) ?
                               BUCKETS : chi_pkg::TABLE_SIZE_RST;
    localparam int CW        = chi_pkg::COUNT_BITS;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_SUM    = 6'b000100,
        ST_DIV    = 6'b001000,
        ST_READ   = 6'b010000,
        ST_MODIFY = 6'b100000
    } state_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic [LINK_BITS-1:0] link;
        logic                 filled;
    } head_entry_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic [LINK_BITS-1:0] link;
    } node_entry_t;

    localparam int HEAD_W = $bits(head_entry_t);
    localparam int NODE_W = $bits(node_entry_t);

    state_t                state_reg, state_next;
    logic [SIZE_BITS-1:0]  size_reg, size_next;
    logic [BKT_BITS-1:0]   clr_reg, clr_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [LINK_BITS-1:0]  nodes_used_reg, nodes_used_next;
    logic [CW-1:0]         inserts_total_reg, inserts_total_next;
    logic [CW-1:0]         collisions_total_reg, collisions_total_next;
    logic                  out_valid_reg, out_valid_next;

    logic [KEY_BITS-1:0]   key_reg;
    logic [HASH_BITS-1:0]  prod_m_reg, prod_u_reg;
    logic [HASH_BITS-1:0]  dvd_reg;
    logic [REM_BITS-1:0]   rem_reg;
    logic [BKT_BITS-1:0]   bucket_reg;
    logic                  collided_reg, dropped_reg;

    logic [EXT_BITS-1:0]   user_ext, movie_ext;
    logic [ID_BITS-1:0]    user_k, movie_k;
    logic [REM_BITS-1:0]   shifted, size_ext, rem_step;
    logic [31:0]           cfg_v;
    logic                  pool_full;
    logic                  accept;

    logic                  head_we;
    logic [BKT_BITS-1:0]   head_addr;
    head_entry_t           head_wr, head_rd;
    logic [HEAD_W-1:0]     head_rdata;
    logic                  node_we;
    node_entry_t           node_wr;
    logic [OUT_EXT-1:0]    bucket_ext;

    // key masking to ID_BITS
    assign user_ext  = EXT_BITS'(user_id);
    assign movie_ext = EXT_BITS'(movie_id);
    assign user_k    = user_ext[ID_BITS-1:0];
    assign movie_k   = movie_ext[ID_BITS-1:0];

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign pool_full = (nodes_used_reg >= LINK_BITS'(POOL_NODES));
    assign head_rd   = head_entry_t'(head_rdata);

    // restoring remainder step
    assign shifted  = {rem_reg[REM_BITS-2:0], dvd_reg[HASH_BITS-1]};
    assign size_ext = REM_BITS'(size_reg);
    assign rem_step = (shifted >= size_ext) ? (shifted - size_ext) : shifted;

    assign cfg_v = 32'(cfg_wdata);

    // head memory access
    always_comb
    begin
        head_addr = (state_reg == ST_CLEAR) ? clr_reg : rem_reg[BKT_BITS-1:0];
        head_we   = 1'b0;
        head_wr   = '0;
        node_we   = 1'b0;
        node_wr.key  = key_reg;
        node_wr.link = head_rd.link;
        case (state_reg)
            ST_CLEAR:
            begin
                head_we = 1'b1;
            end
            ST_MODIFY:
            begin
                if (!head_rd.filled)
                begin
                    head_we        = 1'b1;
                    head_wr.key    = key_reg;
                    head_wr.link   = head_rd.link;
                    head_wr.filled = 1'b1;
                end
                else if (!pool_full)
                begin
                    head_we        = 1'b1;
                    node_we        = 1'b1;
                    head_wr.key    = head_rd.key;
                    head_wr.link   = nodes_used_reg + LINK_BITS'(1);
                    head_wr.filled = 1'b1;
                end
            end
            default:
            begin
                head_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next            = state_reg;
        size_next             = size_reg;
        clr_next              = clr_reg;
        cnt_next              = cnt_reg;
        nodes_used_next       = nodes_used_reg;
        inserts_total_next    = inserts_total_reg;
        collisions_total_next = collisions_total_reg;
        out_valid_next        = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + BKT_BITS'(1);
                if (clr_reg == BKT_BITS'(BUCKETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(HASH_BITS - 1))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_MODIFY;
                end
            end
            ST_MODIFY:
            begin
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
                if (!head_rd.filled)
                begin
                    inserts_total_next = inserts_total_reg + CW'(1);
                end
                else if (!pool_full)
                begin
                    nodes_used_next       = nodes_used_reg + LINK_BITS'(1);
                    inserts_total_next    = inserts_total_reg + CW'(1);
                    collisions_total_next = collisions_total_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        if (cfg_we)
        begin
            if (cfg_v == 32'd0)
            begin
                size_next = SIZE_BITS'(1);
            end
            else if (cfg_v > 32'(BUCKETS))
            begin
                size_next = SIZE_BITS'(BUCKETS);
            end
            else
            begin
                size_next = SIZE_BITS'(cfg_v);
            end
            nodes_used_next = '0;
            clr_next        = '0;
            state_next      = ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_CLEAR;
            size_reg             <= SIZE_BITS'(SIZE_RST);
            clr_reg              <= '0;
            cnt_reg              <= '0;
            nodes_used_reg       <= '0;
            inserts_total_reg    <= '0;
            collisions_total_reg <= '0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            state_reg            <= state_next;
            size_reg             <= size_next;
            clr_reg              <= clr_next;
            cnt_reg              <= cnt_next;
            nodes_used_reg       <= nodes_used_next;
            inserts_total_reg    <= inserts_total_next;
            collisions_total_reg <= collisions_total_next;
            out_valid_reg        <= out_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg    <= {user_k, movie_k};
            prod_m_reg <= HASH_BITS'(movie_k) * HASH_BITS'(chi_pkg::HASH_MOVIE);
            prod_u_reg <= HASH_BITS'(user_k) * HASH_BITS'(chi_pkg::HASH_USER);
        end
        if (state_reg == ST_SUM)
        begin
            dvd_reg <= prod_m_reg + prod_u_reg;
            rem_reg <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= rem_step;
        end
        if (state_reg == ST_MODIFY)
        begin
            bucket_reg   <= rem_reg[BKT_BITS-1:0];
            collided_reg <= head_rd.filled;
            dropped_reg  <= head_rd.filled && pool_full;
        end
    end

    chi_ram #(
        .WIDTH (HEAD_W),
        .DEPTH (BUCKETS)
    ) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .addr  (head_addr),
        .wdata (head_wr),
        .rdata (head_rdata)
    );

    chi_ram #(
        .WIDTH (NODE_W),
        .DEPTH (POOL_NODES)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .addr  (nodes_used_reg[NODE_AW-1:0]),
        .wdata (node_wr),
        .rdata ()
    );

    assign bucket_ext      = OUT_EXT'(bucket_reg);
    assign bucket          = bucket_ext[chi_pkg::BUCKET_OUT_BITS-1:0];
    assign out_valid       = out_valid_reg;
    assign collided        = collided_reg;
    assign dropped         = dropped_reg;
    assign insert_count    = inserts_total_reg;
    assign collision_count = collisions_total_reg;

    `ASSERT_CLK(a_pool_bound, nodes_used_reg <= LINK_BITS'(POOL_NODES), "node count past pool")
    `ASSERT_CLK(a_slot_free, (state_reg == ST_MODIFY) |-> !out_valid_reg, "result slot busy")
    `ASSERT_CLK(a_node_linked, node_we |-> (head_we && head_rd.filled), "node not linked")
    `ASSERT_CLK(a_result_src, $rose(out_valid_reg) |-> $past(state_reg == ST_MODIFY), "stray result")
    `ASSERT_NEXT(a_drop_hold, (state_reg == ST_MODIFY) && head_rd.filled && pool_full, $stable(inserts_total_reg), "count moved on drop")

endmodule
